[hw/rtl/isve_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the inode size varint extractor.
// Used by inode_size_varint_extract_core and its port checker; no dependencies.
package isve_pkg;

  localparam int NEW_VARINT_BIT = 31;
  localparam int POS_BITS       = 12;

  localparam int FLAGS_W = 32;
  localparam int ALEN_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 64;
  localparam int STAT_W  = 3;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  localparam int NFIELD_LO   = 24;
  localparam int NFIELD_W    = 7;
  localparam int MIN_FIELDS  = 5;
  localparam int LAST_VARINT = 8;
  localparam int MAX_VLEN    = 9;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_OLD     = 3'd1,
    ST_SHORT   = 3'd2,
    ST_NOSIZE  = 3'd3,
    ST_OVERRUN = 3'd4
  } status_t;

endpackage

[hw/rtl/inode_size_varint_extract_core.sv]
`timescale 1ns / 1ps
// A result is registered onto m_axis in the cycle after its request is processed, which is the
// cycle of acceptance unless a stalled result holds the request in the skid register.
// Throughput: one request per cycle unless m_axis stalls; the per-byte update is a
// trailing-ones count, one position compare and an 8-bit shift into value_shift.
// Reset (rst, synchronous, active high) empties the skid and result registers and stops any scan.
// Depends on isve_pkg.
module inode_size_varint_extract_core
  import isve_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] inode_flags, [43:32] area_length, [51:44] data_byte, [55:52] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] start_req
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] status, [66:3] size_value, [71:67] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int LEN_W   = 4;
  localparam int SHAMT_W = 7;

  // Skid register.
  logic                 skid_valid;
  logic [IN_DATA_W-1:0] skid_data;
  logic                 skid_user;

  // Scan state.
  logic                scanning;
  logic [3:0]          varint_count;
  logic [LEN_W-1:0]    bytes_left;
  logic [LEN_W-1:0]    cur_length;
  logic [POS_BITS-1:0] byte_position;
  logic [POS_BITS-1:0] area_limit;
  logic [SIZE_W-1:0]   value_shift;

  // Result register.
  status_t           res_status;
  logic [SIZE_W-1:0] res_size;

  // Front of the input: the skid entry when present, else the port.
  logic                 f_valid;
  logic                 f_start;
  logic [IN_DATA_W-1:0] f_data;
  logic [FLAGS_W-1:0]   f_flags;
  logic [ALEN_W-1:0]    f_alen;
  logic [BYTE_W-1:0]    f_byte;
  logic                 advance;
  logic                 s_fire;

  logic [NFIELD_W-1:0]  nfields;
  logic [SIZE_W-1:0]    vs_next;
  logic                 first_byte;
  logic [LEN_W-1:0]     vlen;
  logic [POS_BITS:0]    end_pos;
  logic                 overrun;
  logic [LEN_W-1:0]     left_next;
  logic [LEN_W-1:0]     eff_len;
  logic                 varint_done;
  logic                 finish;
  logic [SHAMT_W-1:0]   shamt;
  logic [SIZE_W-1:0]    decoded;
  logic                 emit;
  status_t              emit_status;
  logic [SIZE_W-1:0]    emit_size;

  function automatic logic [LEN_W-1:0] trailing_ones_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    logic             run;
    n   = LEN_W'(1);
    run = 1'b1;
    for (int i = 0; i < BYTE_W; i++) begin
      if (run && b[i]) begin
        n = n + LEN_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  assign f_valid = skid_valid | s_axis_tvalid;
  assign f_start = skid_valid ? skid_user : s_axis_tuser;
  assign f_data  = skid_valid ? skid_data : s_axis_tdata;
  assign f_flags = f_data[FLAGS_W-1:0];
  assign f_alen  = f_data[FLAGS_W +: ALEN_W];
  assign f_byte  = f_data[FLAGS_W+ALEN_W +: BYTE_W];

  assign advance = f_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !skid_valid;

  always_comb begin
    nfields     = f_flags[NFIELD_LO +: NFIELD_W];
    vs_next     = {f_byte, value_shift[SIZE_W-1:BYTE_W]};
    first_byte  = (bytes_left == '0);
    vlen        = trailing_ones_len(f_byte);
    end_pos     = {1'b0, byte_position} + (POS_BITS+1)'(vlen);
    overrun     = first_byte && (end_pos > {1'b0, area_limit});
    left_next   = first_byte ? (vlen - LEN_W'(1)) : (bytes_left - LEN_W'(1));
    eff_len     = first_byte ? vlen : cur_length;
    varint_done = !overrun && (left_next == '0);
    finish      = varint_done && (varint_count >= 4'(LAST_VARINT));
    shamt       = SHAMT_W'(64) - SHAMT_W'(eff_len) * SHAMT_W'(7);
    // A nine-byte varint is the last eight bytes as they stand.
    decoded     = (eff_len >= LEN_W'(MAX_VLEN)) ? vs_next : (vs_next >> shamt);

    emit        = 1'b0;
    emit_status = ST_OK;
    emit_size   = '0;
    if (f_start) begin
      if (!f_flags[NEW_VARINT_BIT]) begin
        emit        = 1'b1;
        emit_status = ST_OLD;
      end else if (f_alen < ALEN_W'(nfields)) begin
        emit        = 1'b1;
        emit_status = ST_SHORT;
      end else if (nfields < NFIELD_W'(MIN_FIELDS)) begin
        emit        = 1'b1;
        emit_status = ST_NOSIZE;
      end
    end else if (scanning) begin
      if (overrun) begin
        emit        = 1'b1;
        emit_status = ST_OVERRUN;
      end else if (finish) begin
        emit        = 1'b1;
        emit_status = ST_OK;
        emit_size   = decoded;
      end
    end
  end

  // Skid register: holds a request accepted while the result side is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (advance) begin
      skid_valid <= 1'b0;
    end else if (s_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && !advance) begin
      skid_data <= s_axis_tdata;
      skid_user <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
    end else if (advance) begin
      if (f_start) begin
        scanning <= !emit;
      end else if (scanning && emit) begin
        scanning <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (f_start) begin
        varint_count  <= '0;
        bytes_left    <= '0;
        cur_length    <= '0;
        byte_position <= '0;
        area_limit    <= POS_BITS'(f_alen);
        value_shift   <= '0;
      end else if (scanning) begin
        value_shift <= vs_next;
        if (!overrun) begin
          bytes_left    <= left_next;
          byte_position <= end_pos[POS_BITS-1:0] - POS_BITS'(vlen) + POS_BITS'(1);
          if (first_byte) begin
            cur_length <= vlen;
          end
          if (varint_done && !finish) begin
            varint_count <= varint_count + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_status <= emit_status;
      res_size   <= emit_size;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W-SIZE_W-STAT_W)'(0), res_size, res_status};

endmodule

[hw/rtl/isve_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for inode_size_varint_extract_core, bound into each instance of it.
// Depends on isve_pkg.
module isve_checker
  import isve_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending and the input side open.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_OK || m_axis_tdata[2:0] == ST_OLD ||
                       m_axis_tdata[2:0] == ST_SHORT || m_axis_tdata[2:0] == ST_NOSIZE ||
                       m_axis_tdata[2:0] == ST_OVERRUN))
    else $error("unknown status code");

  // Only a successful decode carries a size.
  a_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[66:3] == '0)
    else $error("nonzero size on a failed request");

endmodule

bind inode_size_varint_extract_core isve_checker u_isve_checker (.*);
